### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files that include this header.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication in the next cycle.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/bec_pkg.sv
package bec_pkg;

  // Field and register widths.
  localparam int BTN_IDX_W       = 3;
  localparam int PIN_W           = 1;
  localparam int CNT_W           = 16;
  localparam int EV_W            = 3;
  localparam int BCOUNT_W        = 4;
  localparam int MASK_W          = 8;
  localparam int REP_W           = 8;
  localparam int TABLE_W         = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_BUTTONS_DEF = 8;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] DOWN_TICKS_RST = 16'd2;
  localparam logic [CNT_W-1:0] HOLD_TICKS_RST = 16'd35;

  // Event codes reported per button.
  typedef enum logic [EV_W-1:0] {
    EV_NONE        = 3'd0,
    EV_CLICK_DOWN  = 3'd1,
    EV_HOLD        = 3'd2,
    EV_HOLD_REPEAT = 3'd3,
    EV_CLICK_UP    = 3'd4,
    EV_HOLD_UP     = 3'd5
  } bec_event_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTON_COUNT  = 3'd0,
    REG_PRESS_MASK    = 3'd1,
    REG_DOWN_TICKS    = 3'd2,
    REG_HOLD_TICKS    = 3'd3,
    REG_REPEAT_TABLE  = 3'd4
  } bec_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic mod_start;
    logic load_out;
  } bec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ignore;
    logic need_mod;
    logic mod_busy;
    logic out_free;
  } bec_sts_t;

endpackage

### hdl/bec_if.sv
// Input channel: one scan sample per request.
interface bec_in_if;
  logic                             valid;
  logic                             ready;
  logic [bec_pkg::BTN_IDX_W-1:0]    button_index;
  logic [bec_pkg::PIN_W-1:0]        pin_level;

  modport source (output valid, button_index, pin_level, input ready);
  modport sink   (input valid, button_index, pin_level, output ready);
endinterface

// Result channel: one event report per request.
interface bec_out_if;
  logic                             valid;
  logic                             ready;
  logic [bec_pkg::BTN_IDX_W-1:0]    event_button;
  logic [bec_pkg::EV_W-1:0]         event_code;
  logic                             notify;

  modport source (output valid, event_button, event_code, notify, input ready);
  modport sink   (input valid, event_button, event_code, notify, output ready);
endinterface

// Configuration write channel.
interface bec_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bec_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [bec_pkg::TABLE_W-1:0]      wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### hdl/bec_rem.sv
`include "assert_macros.svh"

// Restoring remainder unit: one dividend bit per cycle, MSB first.
module bec_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bec_pkg::CNT_W-1:0]   dividend,
  input  logic [bec_pkg::REP_W-1:0]   divisor,
  output logic                        busy,
  output logic [bec_pkg::REP_W-1:0]   remainder
);
  import bec_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

  logic                busy_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    dvd_r;
  logic [REP_W-1:0]    div_r;
  logic [REP_W-1:0]    rem_r;
  logic [REP_W:0]      trial;
  logic [REP_W-1:0]    rem_nxt;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    trial = {rem_r, dvd_r[CNT_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = REP_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[REP_W-1:0];
    end
  end

  // Sequencing of the division steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

  `ASSERT_IMP(a_no_restart, start, !busy_r, "remainder unit restarted while busy")
  `ASSERT_IMP(a_rem_below_div, $fell(busy_r) && (div_r != '0), rem_r < div_r,
              "remainder not below divisor at end of division")

endmodule

### hdl/bec_ctrl.sv
`include "assert_macros.svh"

// Sequencer: take a sample, evaluate it, run the remainder unit if needed,
// then hand the result to the output register; out-of-range samples are dropped.
module bec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bec_pkg::bec_sts_t  sts,
  output bec_pkg::bec_cmd_t  cmd
);
  import bec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD,
    ST_PUSH
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  // Command decode from the current state.
  always_comb begin
    cmd.capture   = in_valid && in_ready_r;
    cmd.eval      = (state_r == ST_EVAL);
    cmd.mod_start = (state_r == ST_EVAL) && !sts.ignore && sts.need_mod;
    cmd.load_out  = (state_r == ST_PUSH) && sts.out_free;
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_EVAL;
            in_ready_r <= 1'b0;
          end
        end
        ST_EVAL: begin
          if (sts.ignore) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end else if (sts.need_mod) begin
            state_r <= ST_MOD;
          end else begin
            state_r <= ST_PUSH;
          end
        end
        ST_MOD: begin
          if (!sts.mod_busy) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (sts.out_free) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

  `ASSERT_NXT(a_mod_follows_start, cmd.mod_start, sts.mod_busy && (state_r == ST_MOD),
              "remainder unit not running after start")

endmodule

### hdl/bec_dp.sv
`include "assert_macros.svh"

// Datapath: configuration registers, per-button counters and events,
// classification logic and the output register.
module bec_dp #(
  parameter int NUM_BUTTONS = bec_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bec_pkg::bec_cmd_t               cmd,
  output bec_pkg::bec_sts_t               sts,
  input  logic [bec_pkg::BTN_IDX_W-1:0]   in_button_index,
  input  logic [bec_pkg::PIN_W-1:0]       in_pin_level,
  input  logic                            cfg_we,
  input  logic [bec_pkg::CFG_IDX_W-1:0]   cfg_reg_index,
  input  logic [bec_pkg::TABLE_W-1:0]     cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bec_pkg::BTN_IDX_W-1:0]   out_event_button,
  output logic [bec_pkg::EV_W-1:0]        out_event_code,
  output logic                            out_notify
);
  import bec_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Configuration registers.
  logic [BCOUNT_W-1:0] button_count_r;
  logic [MASK_W-1:0]   mask_r;
  logic [CNT_W-1:0]    down_ticks_r;
  logic [CNT_W-1:0]    hold_ticks_r;
  logic [TABLE_W-1:0]  repeat_r;

  // Per-button state.
  logic [CNT_W-1:0]    press_count_r [NUM_BUTTONS];
  bec_event_t          last_event_r  [NUM_BUTTONS];

  // Captured request and pending result.
  logic [BTN_IDX_W-1:0] pend_idx_r;
  logic [PIN_W-1:0]     pend_level_r;
  bec_event_t           pend_ev_r;
  logic                 pend_notify_r;
  logic                 pend_mod_r;

  // Output register.
  logic                 out_valid_r;
  logic [BTN_IDX_W-1:0] out_idx_r;
  bec_event_t           out_ev_r;
  logic                 out_notify_r;

  // Evaluation signals.
  logic [IDX_W-1:0]     sidx;
  logic                 in_range;
  logic                 pressed;
  logic [CNT_W-1:0]     old_cnt;
  logic [CNT_W-1:0]     inc_cnt;
  logic [CNT_W-1:0]     cnt_new;
  logic [REP_W-1:0]     rep;
  bec_event_t           ev_new;
  logic                 notify_new;
  logic                 need_mod;
  logic                 mod_busy;
  logic [REP_W-1:0]     mod_rem;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_count_r <= '0;
      mask_r         <= '0;
      down_ticks_r   <= DOWN_TICKS_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      repeat_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_index)
        REG_BUTTON_COUNT: button_count_r <= cfg_wr_data[BCOUNT_W-1:0];
        REG_PRESS_MASK:   mask_r         <= cfg_wr_data[MASK_W-1:0];
        REG_DOWN_TICKS:   down_ticks_r   <= cfg_wr_data[CNT_W-1:0];
        REG_HOLD_TICKS:   hold_ticks_r   <= cfg_wr_data[CNT_W-1:0];
        REG_REPEAT_TABLE: repeat_r       <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted sample.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_idx_r   <= in_button_index;
      pend_level_r <= in_pin_level;
    end
  end

  // Classify the sample against the button's counter and the thresholds.
  always_comb begin
    sidx       = IDX_W'(pend_idx_r);
    in_range   = ({1'b0, pend_idx_r} < button_count_r) &&
                 (int'(pend_idx_r) < NUM_BUTTONS);
    pressed    = (pend_level_r == mask_r[pend_idx_r]);
    old_cnt    = press_count_r[sidx];
    inc_cnt    = old_cnt + CNT_W'(1);
    rep        = repeat_r[{pend_idx_r, 3'b000} +: REP_W];
    ev_new     = last_event_r[sidx];
    notify_new = 1'b0;
    need_mod   = 1'b0;
    cnt_new    = inc_cnt;
    if (pressed) begin
      if (inc_cnt == down_ticks_r) begin
        ev_new     = EV_CLICK_DOWN;
        notify_new = 1'b1;
      end else if (inc_cnt == hold_ticks_r) begin
        ev_new     = EV_HOLD;
        notify_new = 1'b1;
      end else if (inc_cnt > hold_ticks_r) begin
        ev_new   = EV_HOLD_REPEAT;
        need_mod = (rep != '0);
      end
    end else begin
      cnt_new = '0;
      if (old_cnt >= down_ticks_r && old_cnt < hold_ticks_r) begin
        ev_new     = EV_CLICK_UP;
        notify_new = 1'b1;
      end else if (old_cnt >= hold_ticks_r) begin
        ev_new     = EV_HOLD_UP;
        notify_new = 1'b1;
      end
    end
  end

  // Per-button state update on a registered index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_count_r[i] <= '0;
        last_event_r[i]  <= EV_NONE;
      end
    end else if (cmd.eval && in_range) begin
      press_count_r[sidx] <= cnt_new;
      last_event_r[sidx]  <= ev_new;
    end
  end

  // Pending result while the remainder unit runs.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pend_ev_r     <= ev_new;
      pend_notify_r <= notify_new;
      pend_mod_r    <= need_mod;
    end
  end

  // Hold-repeat period check.
  bec_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (cnt_new),
    .divisor   (rep),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  // Output register: loaded by the controller, freed when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r    <= pend_idx_r;
      out_ev_r     <= pend_ev_r;
      out_notify_r <= pend_mod_r ? (mod_rem == '0) : pend_notify_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.ignore   = !in_range;
    sts.need_mod = need_mod;
    sts.mod_busy = mod_busy;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_event_button = out_idx_r;
  assign out_event_code   = out_ev_r;
  assign out_notify       = out_notify_r;

  `ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !cmd.load_out,
              "output register overwritten before the request was taken")

endmodule

### hdl/button_event_classifier_core.sv
// Flow: an accepted sample is evaluated and the result is loaded for output, and
// a hold-repeat period check runs the 16-step remainder unit in between.
// A new sample is taken only when the previous one is through; a stalled output
// holds it back, and out-of-range indices give no result.
// Reset: synchronous, active low; clears all counters and events and loads the
// register defaults.
module button_event_classifier_core #(
  parameter int NUM_BUTTONS = bec_pkg::NUM_BUTTONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bec_in_if.sink        in_if,
  bec_out_if.source     out_if,
  bec_cfg_if.sink       cfg_if
);
  import bec_pkg::*;

  bec_cmd_t cmd;
  bec_sts_t sts;
  logic     cfg_we;

  // Registers accept a write in every cycle.
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;

  bec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bec_dp #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_button_index  (in_if.button_index),
    .in_pin_level     (in_if.pin_level),
    .cfg_we           (cfg_we),
    .cfg_reg_index    (cfg_if.reg_index),
    .cfg_wr_data      (cfg_if.wr_data),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_event_button (out_if.event_button),
    .out_event_code   (out_if.event_code),
    .out_notify       (out_if.notify)
  );

endmodule

### sim/tb_top.sv
module tb_top;
  import bec_pkg::*;

  localparam int NB            = NUM_BUTTONS_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 25;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 80;

  // One expected event report, laid out like the result channel.
  typedef struct packed {
    logic [BTN_IDX_W-1:0] button;
    bec_event_t           code;
    logic                 notify;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst_n;

  bec_in_if  in_ch ();
  bec_out_if out_ch ();
  bec_cfg_if cfg_ch ();

  button_event_classifier_core #(.NUM_BUTTONS(NB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow copy of the configuration and of the per-button state.
  logic [BCOUNT_W-1:0] cur_count;
  logic [MASK_W-1:0]   cur_mask;
  logic [CNT_W-1:0]    cur_down;
  logic [CNT_W-1:0]    cur_hold;
  logic [TABLE_W-1:0]  cur_periods;
  logic [CNT_W-1:0]    tick_count [NB];
  bec_event_t          btn_event  [NB];

  scan_report_t pending_reports[$];
  int           fail_count    = 0;
  int           answered_count = 0;
  int           idle_cycles   = 0;
  int           stall_left    = 0;
  bit           gaps_on       = 1'b1;
  bit           stalls_on     = 1'b1;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  wire cfg_fire = cfg_ch.valid && cfg_ch.ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle lengths: mostly back to back or short, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Repeat periods are kept small mostly so that notifies actually occur.
  function automatic logic [REP_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 80) return REP_W'($urandom_range(1, 6));
    return REP_W'($urandom_range(7, 255));
  endfunction

  // Classifies one scan sample against the shadow state. Returns 0 when the
  // button is not registered, in which case nothing changes.
  function automatic bit classify_scan(input logic [BTN_IDX_W-1:0] idx, input logic lvl,
                                       output scan_report_t rep);
    logic [CNT_W-1:0] prev;
    logic [CNT_W-1:0] next;
    logic [REP_W-1:0] period;
    logic             fire;
    fire = 1'b0;
    rep  = '0;
    if (idx >= cur_count) return 1'b0;
    prev = tick_count[idx];
    if (lvl == cur_mask[idx]) begin
      // Pressed: the counter wraps at 16 bits; equality with down wins over hold.
      next = prev + 1'b1;
      tick_count[idx] = next;
      if (next == cur_down) begin
        btn_event[idx] = EV_CLICK_DOWN;
        fire = 1'b1;
      end else if (next == cur_hold) begin
        btn_event[idx] = EV_HOLD;
        fire = 1'b1;
      end else if (next > cur_hold) begin
        btn_event[idx] = EV_HOLD_REPEAT;
        period = cur_periods[REP_W*idx +: REP_W];
        if (period != 0 && (next % period) == 0) fire = 1'b1;
      end
    end else begin
      // Released: the old count decides between click-up, hold-up and nothing.
      tick_count[idx] = '0;
      if (prev >= cur_down && prev < cur_hold) begin
        btn_event[idx] = EV_CLICK_UP;
        fire = 1'b1;
      end else if (prev >= cur_hold) begin
        btn_event[idx] = EV_HOLD_UP;
        fire = 1'b1;
      end
    end
    rep.button = idx;
    rep.code   = btn_event[idx];
    rep.notify = fire;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t MISMATCH: %s", $time, msg);
  endfunction

  // Sends one scan sample and records the report it should produce. The valid
  // line is left high so that the next request can follow without a gap.
  task automatic send_sample(input logic [BTN_IDX_W-1:0] idx, input logic lvl);
    int           gap;
    scan_report_t want;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_index <= idx;
    in_ch.pin_level    <= lvl;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (classify_scan(idx, lvl, want)) begin
      pending_reports.push_back(want);
      answered_count++;
    end
  endtask

  task automatic press_btn(input logic [BTN_IDX_W-1:0] idx);
    send_sample(idx, cur_mask[idx]);
  endtask

  task automatic free_btn(input logic [BTN_IDX_W-1:0] idx);
    send_sample(idx, ~cur_mask[idx]);
  endtask

  // Stops sending, waits for every outstanding report and then lets a
  // possibly dropped sample drain through the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bec_reg_t which, input logic [TABLE_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= which;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (which)
      REG_BUTTON_COUNT: cur_count   = data[BCOUNT_W-1:0];
      REG_PRESS_MASK:   cur_mask    = data[MASK_W-1:0];
      REG_DOWN_TICKS:   cur_down    = data[CNT_W-1:0];
      REG_HOLD_TICKS:   cur_hold    = data[CNT_W-1:0];
      REG_REPEAT_TABLE: cur_periods = data;
      default: ;
    endcase
  endtask

  // Rewrites every register once the block is idle. Unused upper data bits
  // carry random junk, which the block must discard.
  task automatic load_setup(input logic [BCOUNT_W-1:0] count, input logic [MASK_W-1:0] mask,
                            input logic [CNT_W-1:0] down, input logic [CNT_W-1:0] hold,
                            input logic [TABLE_W-1:0] periods);
    logic [TABLE_W-1:0] junk;
    settle();
    junk = {$urandom, $urandom};
    write_reg(REG_BUTTON_COUNT, {junk[TABLE_W-1:BCOUNT_W], count});
    write_reg(REG_PRESS_MASK, {junk[TABLE_W-1:MASK_W], mask});
    write_reg(REG_DOWN_TICKS, {junk[TABLE_W-1:CNT_W], down});
    write_reg(REG_HOLD_TICKS, {junk[TABLE_W-1:CNT_W], hold});
    write_reg(REG_REPEAT_TABLE, periods);
    cfg_ch.valid <= 1'b0;
  endtask

  // After reset no button is registered; then only the count is set so that
  // the reset thresholds and mask are what decide the events.
  task automatic test_reset_defaults();
    send_sample(3'd0, 1'b0);
    send_sample(3'd7, 1'b1);
    settle();
    write_reg(REG_BUTTON_COUNT, 64'd8);
    cfg_ch.valid <= 1'b0;
    press_btn(3'd0);
    press_btn(3'd0);
    free_btn(3'd0);
  endtask

  // Click-down, hold, silent and notifying hold-repeat, hold-up, click-up and
  // a release that comes too early to count.
  task automatic test_click_and_hold();
    load_setup(4'd8, 8'hA5, 16'd2, 16'd4, 64'h0000_0000_0000_0002);
    repeat (6) press_btn(3'd0);
    free_btn(3'd0);
    repeat (2) press_btn(3'd0);
    free_btn(3'd0);
    press_btn(3'd0);
    free_btn(3'd0);
  endtask

  // Down threshold above hold threshold: hold comes first, then repeat, and
  // the down equality still takes priority when it is reached.
  task automatic test_threshold_order();
    load_setup(4'd8, 8'h0F, 16'd5, 16'd3, '0);
    repeat (6) press_btn(3'd1);
    free_btn(3'd1);
  endtask

  // Buttons at or above the registered count give no report.
  task automatic test_ignored_index();
    load_setup(4'd3, 8'h3C, 16'd2, 16'd5, '0);
    send_sample(3'd3, 1'b1);
    send_sample(3'd7, 1'b0);
    press_btn(3'd2);
  endtask

  // Random press sessions: mostly whole press-and-release runs on one button,
  // with stray samples mixed in, over a series of register settings.
  task automatic test_random_sessions();
    int                 down_v;
    int                 hold_v;
    int                 span;
    int                 run;
    int                 start;
    logic [TABLE_W-1:0] periods;
    logic [BTN_IDX_W-1:0] idx;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      if (phase == 0) begin
        load_setup(4'd8, 8'h00, 16'd1, 16'd1, '1);
      end else if (phase == 1) begin
        load_setup(4'd8, 8'hFF, 16'hFFFF, 16'd1, '0);
      end else begin
        down_v = $urandom_range(1, 6);
        if ($urandom_range(0, 99) < 15) hold_v = $urandom_range(1, down_v);
        else hold_v = down_v + $urandom_range(1, 10);
        for (int b = 0; b < NB; b++) periods[REP_W*b +: REP_W] = pick_period();
        load_setup(BCOUNT_W'($urandom_range(1, 8)), MASK_W'($urandom),
                   CNT_W'(down_v), CNT_W'(hold_v), periods);
      end
      span  = (cur_hold > 26) ? 30 : cur_hold + 4;
      if (span < 5) span = 5;
      start = answered_count;
      while (answered_count - start < PHASE_ITEMS) begin
        idx = BTN_IDX_W'($urandom_range(0, cur_count - 1));
        if ($urandom_range(0, 99) < 80) begin
          run = $urandom_range(1, span);
          for (int k = 0; k < run; k++) begin
            press_btn(idx);
            if ($urandom_range(0, 99) < 10) begin
              send_sample(BTN_IDX_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
          end
          free_btn(idx);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_sample(BTN_IDX_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Result side back-pressure: single-cycle and longer stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Each accepted report is compared with the oldest one predicted.
  always @(posedge clk) begin
    scan_report_t want;
    if (rst_n === 1'b1 && out_fire) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("unexpected report: button %0d event %0d notify %0b",
                               out_ch.event_button, out_ch.event_code, out_ch.notify));
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.event_button !== want.button || out_ch.event_code !== want.code ||
            out_ch.notify !== want.notify) begin
          note_failure($sformatf({"expected button %0d event %0d notify %0b, ",
                                  "got button %0d event %0d notify %0b"},
                                 want.button, want.code, want.notify,
                                 out_ch.event_button, out_ch.event_code, out_ch.notify));
        end
      end
    end
  end

  // The run is abandoned when no request moves on any channel for too long.
  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.button_index = '0;
    in_ch.pin_level    = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = REG_BUTTON_COUNT;
    cfg_ch.wr_data     = '0;

    // Shadow state matches the block after reset.
    cur_count   = '0;
    cur_mask    = '0;
    cur_down    = DOWN_TICKS_RST;
    cur_hold    = HOLD_TICKS_RST;
    cur_periods = '0;
    for (int b = 0; b < NB; b++) begin
      tick_count[b] = '0;
      btn_event[b]  = EV_NONE;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_click_and_hold();
    test_threshold_order();
    test_ignored_index();
    test_random_sessions();
    settle();

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bec_pkg.sv
hdl/bec_if.sv
hdl/bec_rem.sv
hdl/bec_ctrl.sv
hdl/bec_dp.sv
hdl/button_event_classifier_core.sv
sim/tb_top.sv
